FILE: design/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types, codes and the character classifier for the expression
// evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

	localparam int NUM_DEPTH = 16;
	localparam int NUM_AW    = (NUM_DEPTH > 1) ? $clog2(NUM_DEPTH) : 1;
	localparam int NUM_CW    = $clog2(NUM_DEPTH + 1);
	localparam int OPR_DEPTH = 16;
	localparam int OPR_AW    = (OPR_DEPTH > 1) ? $clog2(OPR_DEPTH) : 1;
	localparam int OPR_CW    = $clog2(OPR_DEPTH + 1);
	localparam int PAREN_W   = 5;
	localparam logic [PAREN_W-1:0] PAREN_MAX = 5'd31;

	localparam logic signed [31:0] ERROR_VALUE = 32'sd100000;
	localparam logic [7:0] DIGIT_BASE = 8'h30;
	localparam logic [7:0] DIGIT_LAST = 8'h39;
	localparam logic [7:0] CH_OPEN    = 8'h28;
	localparam logic [7:0] CH_CLOSE   = 8'h29;
	localparam logic [7:0] CH_ADD     = 8'h2b;
	localparam logic [7:0] CH_SUB     = 8'h2d;
	localparam logic [7:0] CH_MUL     = 8'h2a;
	localparam logic [7:0] CH_DIV     = 8'h2f;
	localparam logic [7:0] CH_MOD     = 8'h25;

	// command kinds
	localparam logic [2:0] K_SKIP  = 3'd0;
	localparam logic [2:0] K_DIGIT = 3'd1;
	localparam logic [2:0] K_OPEN  = 3'd2;
	localparam logic [2:0] K_CLOSE = 3'd3;
	localparam logic [2:0] K_OPER  = 3'd4;

	// operator codes
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_MOD = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNMATCHED = 3'd1;
	localparam logic [2:0] ST_EMPTY     = 3'd2;
	localparam logic [2:0] ST_UNDERFLOW = 3'd3;
	localparam logic [2:0] ST_OVERFLOW  = 3'd4;
	localparam logic [2:0] ST_DIVZERO   = 3'd5;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] arg;   // digit value or operator code
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_res_t;

	function automatic cmd_t classify(input logic [7:0] ch, input logic last);
		cmd_t c;
		c.kind = K_SKIP;
		c.arg  = 4'd0;
		c.last = last;
		if (ch >= DIGIT_BASE && ch <= DIGIT_LAST) begin
			c.kind = K_DIGIT;
			c.arg  = 4'(ch - DIGIT_BASE);
		end else begin
			case (ch)
				CH_OPEN:  c.kind = K_OPEN;
				CH_CLOSE: c.kind = K_CLOSE;
				CH_ADD: begin
					c.kind = K_OPER;
					c.arg  = {1'b0, OP_ADD};
				end
				CH_SUB: begin
					c.kind = K_OPER;
					c.arg  = {1'b0, OP_SUB};
				end
				CH_MUL: begin
					c.kind = K_OPER;
					c.arg  = {1'b0, OP_MUL};
				end
				CH_DIV: begin
					c.kind = K_OPER;
					c.arg  = {1'b0, OP_DIV};
				end
				CH_MOD: begin
					c.kind = K_OPER;
					c.arg  = {1'b0, OP_MOD};
				end
				default: c.kind = K_SKIP;
			endcase
		end
		return c;
	endfunction

endpackage

FILE: design/pee_if.sv
// ----------------------------------------------------------------------------
// pee_if
// Valid/ready channels for expression characters and results.
// ----------------------------------------------------------------------------
interface pee_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_expr;

	modport source (output valid, output char_code, output end_of_expr, input ready);
	modport sink (input valid, input char_code, input end_of_expr, output ready);
endinterface

interface pee_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [2:0]         status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

FILE: design/pee_front.sv
// ----------------------------------------------------------------------------
// pee_front
// Accepts characters, classifies them into commands and holds one in a stage
// register until the queue takes it.
// ----------------------------------------------------------------------------
module pee_front
	import pee_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	pee_in_if.sink     expr,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	logic valid_s1;
	cmd_t cmd_s1;

	assign expr.ready = !valid_s1 || cmd_ready;
	assign cmd_valid  = valid_s1;
	assign cmd        = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (expr.ready) begin
			valid_s1 <= expr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (expr.ready && expr.valid) begin
			cmd_s1 <= classify(expr.char_code, expr.end_of_expr);
		end
	end

endmodule

FILE: design/pee_queue.sv
// ----------------------------------------------------------------------------
// pee_queue
// Small command queue between the classifier and the execution unit.
// ----------------------------------------------------------------------------
module pee_queue
	import pee_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int QD = 4;
	localparam int QAW = $clog2(QD);

	cmd_t           slot_q [QD];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   fill_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = (fill_q != (QAW+1)'(QD));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = slot_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (QAW+1)'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - (QAW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

endmodule

FILE: design/pee_div.sv
// ----------------------------------------------------------------------------
// pee_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module pee_div
	import pee_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output div_res_t    res
);

	logic        busy_q;
	logic        fix_q;
	logic [5:0]  cnt_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic        negq_q;
	logic        negr_q;
	logic        done_q;
	logic [31:0] qout_q;
	logic [31:0] rout_q;
	logic [32:0] rem_sh;
	logic [32:0] diff;

	assign rem_sh = {rem_q, quo_q[31]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign res    = '{done: done_q, quo: qout_q, rem: rout_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fix_q;
			fix_q  <= !start && busy_q && (cnt_q == 6'd1);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			negq_q <= dividend[31] ^ divisor[31];
			negr_q <= dividend[31];
			quo_q  <= dividend[31] ? (32'd0 - dividend) : dividend;
			den_q  <= divisor[31] ? (32'd0 - divisor) : divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			// restoring step
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (fix_q) begin
			qout_q <= negq_q ? (32'd0 - quo_q) : quo_q;
			rout_q <= negr_q ? (32'd0 - rem_q) : rem_q;
		end
	end

endmodule

FILE: design/pee_back.sv
// ----------------------------------------------------------------------------
// pee_back
// Execution unit: number and operator stacks, error tracking, arithmetic and
// the result register.
// ----------------------------------------------------------------------------
module pee_back
	import pee_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	output logic   cmd_ready,
	input  cmd_t   cmd,
	pee_out_if.source result
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_WB   = 3'd3;
	localparam logic [2:0] S_FRD  = 3'd4;
	localparam logic [2:0] S_FOUT = 3'd5;

	logic [2:0]         state_q;
	logic [NUM_CW-1:0]  ncnt_q;
	logic [OPR_CW-1:0]  ocnt_q;
	logic [PAREN_W-1:0] paren_q;
	logic [2:0]         err_q;
	logic               last_q;
	logic [31:0]        res_q;

	logic [31:0]        num_mem [NUM_DEPTH];
	logic [2:0]         opr_mem [OPR_DEPTH];
	logic [31:0]        top_q;
	logic [31:0]        nxt_q;
	logic [2:0]         opr_q;

	logic               out_v_q;
	logic signed [31:0] out_value_q;
	logic [2:0]         out_status_q;

	logic               num_we;
	logic [NUM_AW-1:0]  num_wa;
	logic [31:0]        num_wd;
	logic               opr_we;
	logic [NUM_AW-1:0]  top_a;
	logic [NUM_AW-1:0]  nxt_a;
	logic [OPR_AW-1:0]  opr_a;
	logic               take;
	logic               close_go;
	logic               div_start;
	div_res_t           div_res;
	logic               out_free;

	assign top_a     = NUM_AW'(ncnt_q - NUM_CW'(1));
	assign nxt_a     = NUM_AW'(ncnt_q - NUM_CW'(2));
	assign opr_a     = OPR_AW'(ocnt_q - OPR_CW'(1));
	assign cmd_ready = (state_q == S_IDLE);
	assign take      = cmd_valid && cmd_ready;
	assign close_go  = take && err_q == ST_OK && cmd.kind == K_CLOSE && paren_q != '0
		&& ncnt_q >= NUM_CW'(2) && ocnt_q != '0;
	assign out_free  = !out_v_q || result.ready;
	assign div_start = (state_q == S_RD) && (opr_q == OP_DIV || opr_q == OP_MOD)
		&& (top_q != 32'd0);

	assign result.valid  = out_v_q;
	assign result.value  = out_value_q;
	assign result.status = out_status_q;

	pee_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (nxt_q),
		.divisor  (top_q),
		.res      (div_res)
	);

	// stack write port selection
	always_comb begin
		num_we = 1'b0;
		num_wa = ncnt_q[NUM_AW-1:0];
		num_wd = {28'd0, cmd.arg};
		opr_we = 1'b0;
		if (take && err_q == ST_OK) begin
			if (cmd.kind == K_DIGIT && ncnt_q < NUM_CW'(NUM_DEPTH)) begin
				num_we = 1'b1;
			end
			if (cmd.kind == K_OPER && ocnt_q < OPR_CW'(OPR_DEPTH)) begin
				opr_we = 1'b1;
			end
		end
		if (state_q == S_WB) begin
			num_we = 1'b1;
			num_wa = nxt_a;
			num_wd = res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (num_we) begin
			num_mem[num_wa] <= num_wd;
		end
		if (opr_we) begin
			opr_mem[ocnt_q[OPR_AW-1:0]] <= cmd.arg[2:0];
		end
		top_q <= num_mem[top_a];
		nxt_q <= num_mem[nxt_a];
		opr_q <= opr_mem[opr_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ncnt_q       <= '0;
			ocnt_q       <= '0;
			paren_q      <= '0;
			err_q        <= ST_OK;
			last_q       <= 1'b0;
			res_q        <= '0;
			out_v_q      <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= ST_OK;
		end else begin
			if (state_q == S_FOUT && out_free) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						last_q <= cmd.last;
						if (close_go) begin
							state_q <= S_RD;
						end else if (cmd.last) begin
							state_q <= S_FRD;
						end
						if (err_q == ST_OK) begin
							case (cmd.kind)
								K_DIGIT: begin
									if (num_we) begin
										ncnt_q <= ncnt_q + NUM_CW'(1);
									end else begin
										err_q <= ST_OVERFLOW;
									end
								end
								K_OPER: begin
									if (opr_we) begin
										ocnt_q <= ocnt_q + OPR_CW'(1);
									end else begin
										err_q <= ST_OVERFLOW;
									end
								end
								K_OPEN: begin
									if (paren_q >= PAREN_MAX) begin
										err_q <= ST_OVERFLOW;
									end else begin
										paren_q <= paren_q + PAREN_W'(1);
									end
								end
								K_CLOSE: begin
									if (paren_q == '0) begin
										err_q <= ST_UNMATCHED;
									end else if (ncnt_q < NUM_CW'(2) || ocnt_q == '0) begin
										err_q <= ST_UNDERFLOW;
									end
								end
								default: begin
								end
							endcase
						end
					end
				end
				S_RD: begin
					case (opr_q)
						OP_ADD: res_q <= nxt_q + top_q;
						OP_SUB: res_q <= nxt_q - top_q;
						OP_MUL: res_q <= 32'(nxt_q * top_q);
						default: begin
						end
					endcase
					if ((opr_q == OP_DIV || opr_q == OP_MOD) && top_q == 32'd0) begin
						err_q   <= ST_DIVZERO;
						state_q <= last_q ? S_FRD : S_IDLE;
					end else if (div_start) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_WB;
					end
				end
				S_DIV: begin
					if (div_res.done) begin
						res_q   <= (opr_q == OP_DIV) ? div_res.quo : div_res.rem;
						state_q <= S_WB;
					end
				end
				S_WB: begin
					ncnt_q  <= ncnt_q - NUM_CW'(1);
					ocnt_q  <= ocnt_q - OPR_CW'(1);
					paren_q <= paren_q - PAREN_W'(1);
					state_q <= last_q ? S_FRD : S_IDLE;
				end
				S_FRD: begin
					state_q <= S_FOUT;
				end
				S_FOUT: begin
					if (out_free) begin
						if (err_q != ST_OK) begin
							out_value_q  <= ERROR_VALUE;
							out_status_q <= err_q;
						end else if (ncnt_q == '0) begin
							out_value_q  <= ERROR_VALUE;
							out_status_q <= ST_EMPTY;
						end else begin
							out_value_q  <= top_q;
							out_status_q <= ST_OK;
						end
						ncnt_q  <= '0;
						ocnt_q  <= '0;
						paren_q <= '0;
						err_q   <= ST_OK;
						last_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_ncnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ncnt_q <= NUM_CW'(NUM_DEPTH))
		else $error("number count beyond stack depth");
	a_ocnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= OPR_CW'(OPR_DEPTH))
		else $error("operator count beyond stack depth");
	a_wb_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WB |=> ncnt_q == $past(ncnt_q) - NUM_CW'(1))
		else $error("writeback did not pop one number");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIV)
		else $error("divider finished outside divide wait");
`endif

endmodule

FILE: design/paren_expression_evaluator_top.sv
// Execution: the unit takes a character while idle; a close paren with + - * then
// runs S_RD and S_WB, with / or % S_RD, S_DIV (32 divider steps plus setup and fix)
// and S_WB. The final character then runs S_FRD and S_FOUT, which reads the stack
// top into the result register and waits for the output. Throughput: one character
// per cycle while the unit is idle; a 4-entry queue lets input run ahead of execution.
// Reset clears counts, error status and all valid flags; the stacks need no clearing.
// ----------------------------------------------------------------------------
// paren_expression_evaluator_top
// Two-stack evaluator for fully parenthesized single-digit expressions.
// ----------------------------------------------------------------------------
module paren_expression_evaluator_top
	import pee_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	pee_in_if.sink    expr,
	pee_out_if.source result
);

	logic fr_valid;
	logic fr_ready;
	cmd_t fr_cmd;
	logic bk_valid;
	logic bk_ready;
	cmd_t bk_cmd;

	pee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.expr      (expr),
		.cmd_valid (fr_valid),
		.cmd_ready (fr_ready),
		.cmd       (fr_cmd)
	);

	pee_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_cmd   (fr_cmd),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_cmd    (bk_cmd)
	);

	pee_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (bk_valid),
		.cmd_ready (bk_ready),
		.cmd       (bk_cmd),
		.result    (result)
	);

endmodule

FILE: test/paren_expression_evaluator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paren_expression_evaluator_top_test
// Sends expression characters through the input channel and scores every
// result against a two-stack predictor kept inside the bench. Stimulus is a
// short directed list, then random well-formed expressions, deep chains,
// stack and paren overflows, wrap cases and broken character soup.
// ----------------------------------------------------------------------------
module paren_expression_evaluator_top_test;
	import pee_pkg::*;

	localparam int LIMIT = 400000;
	localparam int TAIL_CYCLES = 60;
	localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
	} eval_result_t;

	logic clk;
	logic arst_n;

	pee_in_if  expr_ch ();
	pee_out_if result_ch ();

	paren_expression_evaluator_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.expr   (expr_ch),
		.result (result_ch)
	);

	char_item_t   char_queue[$];
	eval_result_t expected_results[$];
	int           accepted_chars = 0;
	int           mismatches = 0;
	int           cycle_cnt = 0;

	// predictor state
	logic [31:0] num_stk [NUM_DEPTH];
	logic [2:0]  opr_stk [OPR_DEPTH];
	int          num_cnt = 0;
	int          opr_cnt = 0;
	int          paren_cnt = 0;
	logic [2:0]  err_code = ST_OK;

	// receiver hold-off
	int   hold_left = 0;
	logic hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic steady_phase();
		return accepted_chars >= 250 && accepted_chars < 550;
	endfunction

	// expected result of one character, applied to the predictor state
	task automatic eval_char(input logic [7:0] ch, input logic last);
		eval_result_t res;
		logic [31:0] lhs, rhs, outv;
		logic signed [31:0] sl, sr;
		logic [2:0] code;
		logic is_op;
		is_op = 1'b0;
		code = OP_ADD;
		outv = '0;
		if (err_code == ST_OK) begin
			if (ch >= DIGIT_BASE && ch <= DIGIT_LAST) begin
				if (num_cnt >= NUM_DEPTH) begin
					err_code = ST_OVERFLOW;
				end else begin
					num_stk[num_cnt] = {24'd0, ch - DIGIT_BASE};
					num_cnt++;
				end
			end else begin
				case (ch)
					CH_OPEN: begin
						if (paren_cnt >= PAREN_MAX)
							err_code = ST_OVERFLOW;
						else
							paren_cnt++;
					end
					CH_CLOSE: begin
						if (paren_cnt == 0) begin
							err_code = ST_UNMATCHED;
						end else if (num_cnt < 2 || opr_cnt == 0) begin
							err_code = ST_UNDERFLOW;
						end else begin
							rhs = num_stk[num_cnt-1];
							lhs = num_stk[num_cnt-2];
							code = opr_stk[opr_cnt-1];
							sl = lhs;
							sr = rhs;
							if ((code == OP_DIV || code == OP_MOD) && rhs == 32'd0) begin
								err_code = ST_DIVZERO;
							end else begin
								case (code)
									OP_ADD: outv = lhs + rhs;
									OP_SUB: outv = lhs - rhs;
									OP_MUL: outv = lhs * rhs;
									OP_DIV: begin
										if (sl == MOST_NEG && sr == -1)
											outv = lhs;
										else
											outv = sl / sr;
									end
									default: begin
										if (sl == MOST_NEG && sr == -1)
											outv = 32'd0;
										else
											outv = sl % sr;
									end
								endcase
								paren_cnt--;
								opr_cnt--;
								num_cnt--;
								num_stk[num_cnt-1] = outv;
							end
						end
					end
					CH_ADD: begin
						is_op = 1'b1;
						code = OP_ADD;
					end
					CH_SUB: begin
						is_op = 1'b1;
						code = OP_SUB;
					end
					CH_MUL: begin
						is_op = 1'b1;
						code = OP_MUL;
					end
					CH_DIV: begin
						is_op = 1'b1;
						code = OP_DIV;
					end
					CH_MOD: begin
						is_op = 1'b1;
						code = OP_MOD;
					end
					default: ;
				endcase
				if (is_op) begin
					if (opr_cnt >= OPR_DEPTH) begin
						err_code = ST_OVERFLOW;
					end else begin
						opr_stk[opr_cnt] = code;
						opr_cnt++;
					end
				end
			end
		end
		if (last) begin
			if (err_code != ST_OK) begin
				res.value = ERROR_VALUE;
				res.status = err_code;
			end else if (num_cnt == 0) begin
				res.value = ERROR_VALUE;
				res.status = ST_EMPTY;
			end else begin
				res.value = num_stk[num_cnt-1];
				res.status = ST_OK;
			end
			expected_results.push_back(res);
			num_cnt = 0;
			opr_cnt = 0;
			paren_cnt = 0;
			err_code = ST_OK;
		end
	endtask

	// ---------------- stimulus building ----------------

	task automatic add_char(input logic [7:0] ch, input logic last);
		char_item_t it;
		it.ch = ch;
		it.last = last;
		char_queue.push_back(it);
	endtask

	task automatic add_str(input string s, input logic last);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i], last && (i == s.len() - 1));
	endtask

	task automatic close_expr();
		char_queue[$].last = 1'b1;
	endtask

	// any byte outside the digit and operator range
	function automatic logic [7:0] noise_byte();
		if ($urandom_range(1) == 0)
			return 8'($urandom_range(8'h00, 8'h24));
		return 8'($urandom_range(8'h3a, 8'hff));
	endfunction

	function automatic logic [7:0] rand_digit();
		return DIGIT_BASE + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(4))
			0: return CH_ADD;
			1: return CH_SUB;
			2: return CH_MUL;
			3: return CH_DIV;
			default: return CH_MOD;
		endcase
	endfunction

	task automatic gen_expr(input int depth);
		if (depth == 0 || $urandom_range(3) == 0) begin
			if ($urandom_range(19) == 0)
				add_char(noise_byte(), 1'b0);
			add_char(rand_digit(), 1'b0);
		end else begin
			add_char(CH_OPEN, 1'b0);
			gen_expr(depth - 1);
			add_char(rand_op(), 1'b0);
			gen_expr(depth - 1);
			add_char(CH_CLOSE, 1'b0);
		end
	endtask

	initial begin
		int pick, n;
		// directed part
		add_str("(1+2)", 1'b1);
		add_str("(3-8)", 1'b1);
		add_str("(4*9)", 1'b1);
		add_str("(7%0)", 1'b1);           // divide by zero
		add_str(")9", 1'b1);              // close without open, later chars ignored
		add_str("(5)", 1'b1);             // close with one number and no operator
		add_char(8'h00, 1'b0);
		add_char(8'hff, 1'b1);            // nothing pushed: empty result
		add_str("7", 1'b1);

		// random part
		while (char_queue.size() < 1330) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				gen_expr($urandom_range(4));
				if ($urandom_range(9) == 0)
					add_char(noise_byte(), 1'b0);
				close_expr();
			end else if (pick < 78) begin
				// right-leaning chain, at its deeper settings enough to fill the number stack
				n = $urandom_range(10, 17);
				for (int i = 0; i < n; i++) begin
					add_char(CH_OPEN, 1'b0);
					add_char(rand_digit(), 1'b0);
					add_char(rand_op(), 1'b0);
				end
				add_char(rand_digit(), 1'b0);
				for (int i = 0; i < n; i++)
					add_char(CH_CLOSE, 1'b0);
				close_expr();
			end else if (pick < 82) begin
				// 2 * 8^10 wraps to the most negative value, then / or % by -1
				add_char(CH_OPEN, 1'b0);
				for (int i = 0; i < 10; i++)
					add_char(CH_OPEN, 1'b0);
				add_char(DIGIT_BASE + 8'd2, 1'b0);
				for (int i = 0; i < 10; i++)
					add_str("*8)", 1'b0);
				add_char($urandom_range(1) ? CH_DIV : CH_MOD, 1'b0);
				add_str("(0-1))", 1'b1);
			end else if (pick < 85) begin
				n = $urandom_range(30, 33);
				for (int i = 0; i < n; i++)
					add_char(CH_OPEN, 1'b0);
				add_char(rand_digit(), 1'b1);
			end else if (pick < 88) begin
				add_char(CH_OPEN, 1'b0);
				add_char(rand_digit(), 1'b0);
				n = $urandom_range(15, 18);
				for (int i = 0; i < n; i++)
					add_char(rand_op(), 1'b0);
				add_char(rand_digit(), 1'b1);
			end else begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(5))
						0, 1: add_char(rand_digit(), 1'b0);
						2: add_char(rand_op(), 1'b0);
						3: add_char(CH_OPEN, 1'b0);
						4: add_char(CH_CLOSE, 1'b0);
						default: add_char(noise_byte(), 1'b0);
					endcase
				end
				close_expr();
			end
		end

		@(posedge arst_n);
		while (char_queue.size() != 0 || expr_ch.valid)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// ---------------- driver ----------------

	always @(posedge clk or negedge arst_n) begin : drive
		char_item_t it;
		if (!arst_n) begin
			expr_ch.valid <= 1'b0;
			expr_ch.char_code <= 8'h00;
			expr_ch.end_of_expr <= 1'b0;
		end else begin
			if (expr_ch.valid && expr_ch.ready) begin
				eval_char(expr_ch.char_code, expr_ch.end_of_expr);
				accepted_chars <= accepted_chars + 1;
			end
			if (!expr_ch.valid || expr_ch.ready) begin
				if (char_queue.size() != 0 &&
				    (steady_phase() || $urandom_range(99) >= 36)) begin
					it = char_queue.pop_front();
					expr_ch.valid <= 1'b1;
					expr_ch.char_code <= it.ch;
					expr_ch.end_of_expr <= it.last;
				end else begin
					expr_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- receiver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			result_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && accepted_chars >= 700) begin
			// long stall so the input side backs up
			result_ch.ready <= 1'b0;
			hold_left <= 400;
			hold_done <= 1'b1;
		end else begin
			result_ch.ready <= steady_phase() || ($urandom_range(99) >= 36);
		end
	end

	// ---------------- result checking ----------------

	always @(posedge clk) begin : score
		eval_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: value %0d status %0d",
					         result_ch.value, result_ch.status);
			end else begin
				want = expected_results.pop_front();
				if (want.value !== result_ch.value || want.status !== result_ch.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value %0d status %0d, got value %0d status %0d",
						         want.value, want.status, result_ch.value, result_ch.status);
				end
			end
		end
	end

endmodule
